/* hdl/assert_macros.svh */
// Assertion macros shared by the RTL.
// Expects clk and arst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising clk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that cond implies prop in the same cycle.
`define ASSERT_IMPLY(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// Check that cond implies prop in the next cycle.
`define ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

/* hdl/lng_pkg.sv */
// Shared types and constants for the lattice neighbor generator.
// No dependencies.
package lng_pkg;

	localparam int IDX_W          = 30;
	localparam int EXT_W          = 11;
	localparam int DIMS_DEF       = 3;
	localparam int MAX_EXTENT_DEF = 1024;

	localparam logic [2:0] DIR_BACK = 3'd3;

	typedef enum logic [1:0] {
		ST_VALID,
		ST_NONE,
		ST_RANGE
	} status_t;

	typedef enum logic [1:0] {
		REG_EXTENT_0,
		REG_EXTENT_1,
		REG_EXTENT_2,
		REG_PERIODIC
	} reg_idx_t;

	typedef struct packed {
		logic [IDX_W-1:0] site_index;
	} site_t;

	typedef struct packed {
		logic [IDX_W-1:0] neighbor_index;
		logic [2:0]       direction;
		status_t          status;
		logic             last;
	} result_t;

endpackage

/* hdl/lng_if.sv */
// Valid/ready channel carrying one payload type per transaction.
// Payload types come from lng_pkg.
interface lng_if #(
	parameter type T = lng_pkg::site_t
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* hdl/lng_emit.sv */
// Output stage: holds one site's neighbor set and sends one result per transaction.
// Depends on lng_pkg and lng_if.
module lng_emit #(
	parameter int IW   = lng_pkg::IDX_W,
	parameter int DIMS = lng_pkg::DIMS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          tail_valid,
	input  logic [2*DIMS-1:0]             tail_mask,
	input  logic [2*DIMS-1:0][IW-1:0]     tail_idx,
	input  lng_pkg::status_t              tail_status,
	output logic                          take,
	lng_if.source                         neighbors
);
	localparam int NDIR = 2 * DIMS;

	logic                      busy_q;
	logic [NDIR-1:0]           mask_q;
	logic [NDIR-1:0][IW-1:0]   idx_q;
	lng_pkg::status_t          status_q;

	logic [NDIR-1:0] rest;
	logic [2:0]      pick;
	logic            fin;

	always_comb begin
		pick = '0;
		for (int p = NDIR - 1; p >= 0; p--) begin
			if (mask_q[p]) begin
				pick = 3'(p);
			end
		end
		rest = mask_q & ~(NDIR'(1) << pick);
		fin = (status_q != lng_pkg::ST_VALID) || (rest == '0);
		take = !busy_q || (neighbors.ready && fin);

		neighbors.valid = busy_q;
		neighbors.data.status = status_q;
		neighbors.data.last = fin;
		if (status_q != lng_pkg::ST_VALID) begin
			neighbors.data.neighbor_index = '0;
			neighbors.data.direction = '0;
		end else begin
			neighbors.data.neighbor_index = idx_q[pick];
			if (pick < 3'(DIMS)) begin
				neighbors.data.direction = pick;
			end else begin
				neighbors.data.direction = lng_pkg::DIR_BACK + pick - 3'(DIMS);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (take) begin
			busy_q <= tail_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			mask_q <= tail_mask;
			idx_q <= tail_idx;
			status_q <= tail_status;
		end else if (neighbors.ready) begin
			mask_q <= rest;
		end
	end

endmodule

/* hdl/lattice_neighbor_generator.sv */
// Nearest-neighbor generator for a row-major lattice of DIMS dimensions. A site
// enters when sites.ready is high; its coordinates are found by a restoring
// divider with one quotient bit per pipeline stage, (DIMS-1)*clog2(MAX_EXTENT)
// stages. Each site then yields 1 to 2*DIMS results, one result per cycle while
// the receiver is ready. After a configuration write, inputs are held off while
// strides and lattice size are recomputed by a chain of registered multipliers.
module lattice_neighbor_generator #(
	parameter int DIMS       = lng_pkg::DIMS_DEF,
	parameter int MAX_EXTENT = lng_pkg::MAX_EXTENT_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	lng_if.sink                       sites,
	lng_if.source                     neighbors,
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_index,
	input  logic [lng_pkg::EXT_W-1:0] cfg_data
);
	`include "assert_macros.svh"

	localparam int IW    = lng_pkg::IDX_W;
	localparam int SW    = IW + 1;
	localparam int QW    = $clog2(MAX_EXTENT);
	localparam int EW    = $clog2(MAX_EXTENT + 1);
	localparam int NSTEP = (DIMS - 1) * QW;
	localparam int NDIR  = 2 * DIMS;
	localparam int HW    = $clog2(DIMS + 2);
	localparam int EXT_CLAMP_W = lng_pkg::EXT_W;

	logic [DIMS-1:0][EW-1:0] ext_q;
	logic                    periodic_q;
	logic [DIMS-1:0][SW-1:0] stride_q;
	logic [DIMS-1:0][SW-1:0] span_q;
	logic [SW-1:0]           size_q;
	logic [HW-1:0]           hold_q;

	logic [EXT_CLAMP_W-1:0]  cfg_ext;

	logic                    adv;
	logic                    take;

	logic                    v_s     [NSTEP+1];
	logic [IW-1:0]           site_s  [NSTEP+1];
	logic [IW-1:0]           rem_s   [NSTEP+1];
	logic [DIMS-1:0][QW-1:0] coord_s [NSTEP+1];
	logic                    oor_s   [NSTEP+1];

	logic                    nbv_q;
	logic [NDIR-1:0]         nbmask_q;
	logic [NDIR-1:0][IW-1:0] nbidx_q;
	lng_pkg::status_t        nbst_q;

	logic [NDIR-1:0]         mask_c;
	logic [NDIR-1:0][IW-1:0] idx_c;
	lng_pkg::status_t        st_c;
	logic [QW-1:0]           c_c;
	logic [EW-1:0]           e_c;
	logic                    wrap_c;
	logic [SW-1:0]           site_c;

	// configuration
	always_comb begin
		if (cfg_data == '0) begin
			cfg_ext = EXT_CLAMP_W'(1);
		end else if (cfg_data > EXT_CLAMP_W'(MAX_EXTENT)) begin
			cfg_ext = EXT_CLAMP_W'(MAX_EXTENT);
		end else begin
			cfg_ext = cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < DIMS; d++) begin
				ext_q[d] <= EW'(1);
				stride_q[d] <= SW'(1);
				span_q[d] <= '0;
			end
			periodic_q <= 1'b1;
			size_q <= SW'(1);
			hold_q <= '0;
		end else begin
			for (int d = 0; d < DIMS; d++) begin
				if (cfg_we && cfg_index == 2'(lng_pkg::REG_EXTENT_0) + 2'(d)) begin
					ext_q[d] <= EW'(cfg_ext);
				end
			end
			if (cfg_we && cfg_index == 2'(lng_pkg::REG_PERIODIC)) begin
				periodic_q <= cfg_data[0];
			end
			for (int d = 0; d < DIMS - 1; d++) begin
				stride_q[d] <= SW'(stride_q[d+1] * ext_q[d+1]);
			end
			stride_q[DIMS-1] <= SW'(1);
			for (int d = 0; d < DIMS; d++) begin
				span_q[d] <= SW'(stride_q[d] * (ext_q[d] - EW'(1)));
			end
			size_q <= SW'(stride_q[0] * ext_q[0]);
			if (cfg_we) begin
				hold_q <= HW'(DIMS + 1);
			end else if (hold_q != '0) begin
				hold_q <= hold_q - HW'(1);
			end
		end
	end

	// pipeline entry
	assign adv = !nbv_q || take;
	assign sites.ready = adv && (hold_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (adv) begin
			v_s[0] <= sites.valid && sites.ready;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			site_s[0] <= sites.data.site_index;
			rem_s[0] <= sites.data.site_index;
			coord_s[0] <= '0;
			oor_s[0] <= {1'b0, sites.data.site_index} >= size_q;
		end
	end

	// divider: one quotient bit per stage
	for (genvar j = 0; j < NSTEP; j++) begin : g_div
		localparam int D = j / QW;
		localparam int B = QW - 1 - (j % QW);
		logic [SW+QW-1:0]        trial;
		logic [SW+QW-1:0]        remx;
		logic                    ge;
		logic [DIMS-1:0][QW-1:0] cnext;

		assign trial = (SW+QW)'(stride_q[D]) << B;
		assign remx = (SW+QW)'(rem_s[j]);
		assign ge = remx >= trial;

		always_comb begin
			cnext = coord_s[j];
			cnext[D][B] = ge;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j+1] <= 1'b0;
			end else if (adv) begin
				v_s[j+1] <= v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				site_s[j+1] <= site_s[j];
				oor_s[j+1] <= oor_s[j];
				coord_s[j+1] <= cnext;
				rem_s[j+1] <= ge ? IW'(remx - trial) : rem_s[j];
			end
		end
	end

	// neighbor set
	always_comb begin
		site_c = {1'b0, site_s[NSTEP]};
		mask_c = '0;
		idx_c = '0;
		c_c = '0;
		e_c = '0;
		wrap_c = 1'b0;
		for (int d = 0; d < DIMS; d++) begin
			c_c = (d == DIMS - 1) ? rem_s[NSTEP][QW-1:0] : coord_s[NSTEP][d];
			e_c = ext_q[d];
			wrap_c = periodic_q && (e_c > EW'(1));
			if ((EW+1)'(c_c) + (EW+1)'(1) < (EW+1)'(e_c)) begin
				mask_c[d] = 1'b1;
				idx_c[d] = IW'(site_c + stride_q[d]);
			end else begin
				mask_c[d] = wrap_c;
				idx_c[d] = IW'(site_c - span_q[d]);
			end
			if (c_c != '0) begin
				mask_c[DIMS+d] = 1'b1;
				idx_c[DIMS+d] = IW'(site_c - stride_q[d]);
			end else begin
				mask_c[DIMS+d] = wrap_c;
				idx_c[DIMS+d] = IW'(site_c + span_q[d]);
			end
		end
		if (oor_s[NSTEP]) begin
			st_c = lng_pkg::ST_RANGE;
			mask_c = '0;
		end else if (mask_c == '0) begin
			st_c = lng_pkg::ST_NONE;
		end else begin
			st_c = lng_pkg::ST_VALID;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nbv_q <= 1'b0;
		end else if (adv) begin
			nbv_q <= v_s[NSTEP];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nbmask_q <= mask_c;
			nbidx_q <= idx_c;
			nbst_q <= st_c;
		end
	end

	lng_emit #(
		.IW   (IW),
		.DIMS (DIMS)
	) u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.tail_valid  (nbv_q),
		.tail_mask   (nbmask_q),
		.tail_idx    (nbidx_q),
		.tail_status (nbst_q),
		.take        (take),
		.neighbors   (neighbors)
	);

	`ASSERT_IMPLY(a_flag_is_last, neighbors.valid && neighbors.data.status != lng_pkg::ST_VALID, neighbors.data.last, "status result not marked last")
	`ASSERT_IMPLY(a_dir_range, neighbors.valid && neighbors.data.status == lng_pkg::ST_VALID, neighbors.data.direction < 3'(DIMS) || (neighbors.data.direction >= lng_pkg::DIR_BACK && neighbors.data.direction < lng_pkg::DIR_BACK + 3'(DIMS)), "direction out of range")
	`ASSERT_NEXT(a_tail_hold, nbv_q && !take, nbv_q && $stable(nbmask_q) && $stable(nbidx_q), "stalled neighbor set changed")

endmodule

/* verif/lng_tb_if.sv */
`timescale 1ns / 1ps
// Testbench-side note: the channel interface lng_if comes from hdl/lng_if.sv.
// This file holds a small helper package with the number of lattice sets used by the stimulus.
// No dependencies.
package lng_tb_pkg;
	localparam int LAT_SETS = 8;
endpackage

/* verif/lng_checker.sv */
`timescale 1ns / 1ps
// Result checker for lattice_neighbor_generator: watches both channels and the
// configuration port, predicts the neighbor list of each site and compares.
// Depends on lng_pkg.
module lng_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      site_valid,
	input  logic                      site_ready,
	input  lng_pkg::site_t            site_data,
	input  logic                      nb_valid,
	input  logic                      nb_ready,
	input  lng_pkg::result_t          nb_data,
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_index,
	input  logic [lng_pkg::EXT_W-1:0] cfg_data,
	output int                        errors,
	output int                        pending,
	output int                        sites_seen,
	output int                        neighbors_seen
);
	logic [lng_pkg::EXT_W-1:0] extent [3];
	logic                      periodic;
	lng_pkg::result_t          expected_neighbors [$];

	function automatic longint clamp_len(logic [lng_pkg::EXT_W-1:0] e);
		if (e == 0) return 1;
		if (e > 1024) return 1024;
		return e;
	endfunction

	task automatic predict_neighbors(logic [lng_pkg::IDX_W-1:0] site_in);
		longint len [3];
		longint stride [3];
		longint coord [3];
		longint site, rem, lat_size;
		int count;
		lng_pkg::result_t r;
		site = site_in;
		count = 0;
		for (int d = 0; d < 3; d++) len[d] = clamp_len(extent[d]);
		stride[2] = 1;
		stride[1] = len[2];
		stride[0] = len[2] * len[1];
		lat_size = stride[0] * len[0];
		if (site >= lat_size) begin
			r = '{neighbor_index: '0, direction: '0, status: lng_pkg::ST_RANGE, last: 1'b1};
			expected_neighbors.push_back(r);
			return;
		end
		rem = site;
		for (int d = 0; d < 3; d++) begin
			coord[d] = rem / stride[d];
			rem = rem % stride[d];
		end
		for (int pass = 0; pass < 2; pass++) begin
			for (int d = 0; d < 3; d++) begin
				longint nb;
				bit hit;
				hit = 1'b0;
				nb = 0;
				if (pass == 0) begin
					if (coord[d] + 1 < len[d]) begin
						nb = site + stride[d];
						hit = 1'b1;
					end else if (periodic && len[d] > 1) begin
						nb = site - (len[d] - 1) * stride[d];
						hit = 1'b1;
					end
				end else begin
					if (coord[d] > 0) begin
						nb = site - stride[d];
						hit = 1'b1;
					end else if (periodic && len[d] > 1) begin
						nb = site + (len[d] - 1) * stride[d];
						hit = 1'b1;
					end
				end
				if (hit) begin
					r.neighbor_index = nb[lng_pkg::IDX_W-1:0];
					r.direction = (pass == 0) ? 3'(d) : lng_pkg::DIR_BACK + 3'(d);
					r.status = lng_pkg::ST_VALID;
					r.last = 1'b0;
					expected_neighbors.push_back(r);
					count++;
				end
			end
		end
		if (count == 0) begin
			r = '{neighbor_index: '0, direction: '0, status: lng_pkg::ST_NONE, last: 1'b1};
			expected_neighbors.push_back(r);
		end else begin
			expected_neighbors[$].last = 1'b1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			extent = '{11'd1, 11'd1, 11'd1};
			periodic = 1'b1;
			errors = 0;
			sites_seen = 0;
			neighbors_seen = 0;
			expected_neighbors.delete();
			pending = 0;
		end else begin
			if (nb_valid && nb_ready) begin
				neighbors_seen++;
				if (expected_neighbors.size() == 0) begin
					$error("unexpected neighbor transaction %p", nb_data);
					errors++;
				end else begin
					lng_pkg::result_t e;
					e = expected_neighbors.pop_front();
					if (nb_data.neighbor_index !== e.neighbor_index) begin
						$error("neighbor_index expected %0d actual %0d",
							e.neighbor_index, nb_data.neighbor_index);
						errors++;
					end
					if (nb_data.direction !== e.direction) begin
						$error("direction expected %0d actual %0d",
							e.direction, nb_data.direction);
						errors++;
					end
					if (nb_data.status !== e.status) begin
						$error("status expected %0d actual %0d", e.status, nb_data.status);
						errors++;
					end
					if (nb_data.last !== e.last) begin
						$error("last expected %0d actual %0d", e.last, nb_data.last);
						errors++;
					end
				end
			end
			if (site_valid && site_ready) begin
				sites_seen++;
				predict_neighbors(site_data.site_index);
			end
			if (cfg_we) begin
				case (cfg_index)
					lng_pkg::REG_EXTENT_0: extent[0] = cfg_data;
					lng_pkg::REG_EXTENT_1: extent[1] = cfg_data;
					lng_pkg::REG_EXTENT_2: extent[2] = cfg_data;
					lng_pkg::REG_PERIODIC: periodic = cfg_data[0];
				endcase
			end
			pending = expected_neighbors.size();
		end
	end
endmodule

/* verif/lattice_neighbor_generator_tb.sv */
`timescale 1ns / 1ps
// Top of the lattice_neighbor_generator testbench: clock, reset, configuration
// phases, site stimulus and receiver stalls. Depends on lng_pkg, lng_tb_pkg, lng_if, lng_checker.
module lattice_neighbor_generator_tb;
	logic                      clk;
	logic                      arst_n;
	logic                      cfg_we;
	logic [1:0]                cfg_index;
	logic [lng_pkg::EXT_W-1:0] cfg_data;
	int                        errors, pending, sites_seen, neighbors_seen;
	int                        send_idle_pct, recv_stall_pct;
	bit                        hold_off;

	lng_if #(.T(lng_pkg::site_t))   sites ();
	lng_if #(.T(lng_pkg::result_t)) neighbors ();

	lattice_neighbor_generator DUT (
		.clk(clk), .arst_n(arst_n), .sites(sites.sink), .neighbors(neighbors.source),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	lng_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.site_valid(sites.valid), .site_ready(sites.ready), .site_data(sites.data),
		.nb_valid(neighbors.valid), .nb_ready(neighbors.ready), .nb_data(neighbors.data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .pending(pending), .sites_seen(sites_seen),
		.neighbors_seen(neighbors_seen)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("lattice_neighbor_generator_tb NOT OK");
		$finish;
	end

	// receiver stalls
	initial begin
		neighbors.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off) neighbors.ready <= 1'b0;
			else neighbors.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic write_reg(lng_pkg::reg_idx_t idx, logic [lng_pkg::EXT_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic configure(logic [lng_pkg::EXT_W-1:0] e0, logic [lng_pkg::EXT_W-1:0] e1,
		logic [lng_pkg::EXT_W-1:0] e2, bit per);
		write_reg(lng_pkg::REG_EXTENT_0, e0);
		write_reg(lng_pkg::REG_EXTENT_1, e1);
		write_reg(lng_pkg::REG_EXTENT_2, e2);
		write_reg(lng_pkg::REG_PERIODIC, {10'd0, per});
	endtask

	task automatic drain;
		sites.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic send_site(logic [lng_pkg::IDX_W-1:0] s);
		while ($urandom_range(99) < send_idle_pct) begin
			sites.valid <= 1'b0;
			@(negedge clk);
		end
		sites.valid <= 1'b1;
		sites.data <= lng_pkg::site_t'(s);
		@(posedge clk);
		while (!sites.ready) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic longint lat_size(logic [lng_pkg::EXT_W-1:0] e0,
		logic [lng_pkg::EXT_W-1:0] e1, logic [lng_pkg::EXT_W-1:0] e2);
		longint a, b, c;
		a = (e0 == 0) ? 1 : (e0 > 1024 ? 1024 : e0);
		b = (e1 == 0) ? 1 : (e1 > 1024 ? 1024 : e1);
		c = (e2 == 0) ? 1 : (e2 > 1024 ? 1024 : e2);
		return a * b * c;
	endfunction

	initial begin
		logic [lng_pkg::EXT_W-1:0] e0, e1, e2;
		longint sz, s;
		bit per;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		sites.valid = 1'b0;
		sites.data = '0;
		hold_off = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (3) @(negedge clk);

		// reset lattice is a single site: no neighbors, then out of range
		send_site(30'd0);
		send_site(30'd1);
		send_site(30'h3FFFFFFF);
		drain();

		configure(11'd4, 11'd3, 11'd2, 1'b1);
		send_site(30'd0);
		send_site(30'd23);
		send_site(30'd9);
		send_site(30'd24);
		drain();
		configure(11'd4, 11'd3, 11'd2, 1'b0);
		send_site(30'd0);
		send_site(30'd23);
		send_site(30'd9);
		drain();
		// zero and oversize extents clamp
		configure(11'd0, 11'd2047, 11'd1025, 1'b1);
		send_site(30'd0);
		send_site(30'd1048575);
		send_site(30'd1048576);
		send_site(30'd524800);
		drain();
		configure(11'd1024, 11'd1024, 11'd1024, 1'b0);
		send_site(30'h3FFFFFFF);
		send_site(30'd0);
		send_site(30'h2AAAAAAA);
		send_site(30'h15555555);
		drain();

		// fill the block while the receiver holds off
		configure(11'd5, 11'd5, 11'd5, 1'b1);
		hold_off = 1'b1;
		fork
			begin
				for (int i = 0; i < 40; i++) send_site(30'($urandom_range(124)));
				sites.valid <= 1'b0;
			end
			begin
				repeat (200) @(negedge clk);
				hold_off = 1'b0;
			end
		join
		drain();

		for (int ph = 0; ph < lng_tb_pkg::LAT_SETS; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 63; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 63; end
				default: begin send_idle_pct = 6; recv_stall_pct = 6; end
			endcase
			if (ph == 7) begin
				e0 = 11'd1; e1 = 11'd1; e2 = 11'd2;
			end else begin
				e0 = 11'($urandom_range(ph < 4 ? 6 : 1024));
				e1 = 11'($urandom_range(ph < 4 ? 6 : 1024));
				e2 = 11'($urandom_range(ph < 2 ? 6 : 2047));
			end
			per = $urandom_range(1);
			configure(e0, e1, e2, per);
			sz = lat_size(e0, e1, e2);
			for (int i = 0; i < 13; i++) begin
				case ($urandom_range(9))
					0: s = $urandom();
					1: s = sz - 1;
					2: s = sz;
					default: s = {$urandom(), $urandom()} % sz;
				endcase
				send_site(s[lng_pkg::IDX_W-1:0] & 30'h3FFFFFFF);
			end
			drain();
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
		drain();
		$display("covered %0d sites and %0d neighbor transactions over several lattices",
			sites_seen, neighbors_seen);
		$display("periodic and open boundaries, clamped extents, stalls and backpressure");
		if (errors == 0)
			$display("lattice_neighbor_generator_tb OK");
		else
			$display("lattice_neighbor_generator_tb NOT OK");
		$finish;
	end
endmodule
